// ===== rtl/ida_pkg.sv =====
// ----------------------------------------------------------------------------
// ida_pkg
// Shared types and codes for the identifier allocator.
// ----------------------------------------------------------------------------
package ida_pkg;

    // Result status carried on the master-side tuser
    typedef logic [1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EXHAUSTED = 2'd1;
    localparam status_t ST_DUPLICATE = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Request operation
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Allocation order
    localparam logic MODE_UNUSED_FIRST = 1'b0;
    localparam logic MODE_FREED_FIRST  = 1'b1;

endpackage

// ===== rtl/id_allocator_with_free_list_unit.sv =====
// ----------------------------------------------------------------------------
// id_allocator_with_free_list_unit
// Hands out identifiers from a counter and a store of freed numbers.
// Allocate from the counter: the result goes straight to the finish state, and
// a new request is taken only once the block is back in idle. Any request that
// scans the slot RAM reads it through its one-entry-per-cycle read port; an
// allocate stops at the first occupied slot. After reset a clearing pass marks
// every slot empty while s_tready stays low.
// ----------------------------------------------------------------------------
module id_allocator_with_free_list_unit #(
    parameter int FREE_SLOTS   = 64,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // value[31:0]
    input  logic [1:0]        s_tuser,   // operation[0], mode[1]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // number[31:0]
    output ida_pkg::status_t  m_tuser    // status[1:0]
);

    import ida_pkg::*;

    localparam int NW = NUMBER_WIDTH;
    localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(FREE_SLOTS - 1);
    localparam logic [NW-1:0] NUM_ONES = '1;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Control state
    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic          issue_done_reg, issue_done_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          dup_reg, dup_next;
    logic          have_empty_reg, have_empty_next;
    logic [AW-1:0] empty_at_reg, empty_at_next;
    logic [NW-1:0] next_unused_reg, next_unused_next;
    logic          sat_reg, sat_next;
    logic          out_valid_reg, out_valid_next;

    // Payload
    logic          op_reg, op_next;
    logic [NW-1:0] val_reg, val_next;
    logic [NW-1:0] res_num_reg, res_num_next;
    status_t       res_status_reg, res_status_next;
    logic [31:0]   out_num_reg, out_num_next;
    status_t       out_status_reg, out_status_next;

    // Slot RAM: valid bit on top of the stored number
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [NW:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [NW:0]   ram_rdata;

    logic          entry_valid;
    logic [NW-1:0] entry_num;
    logic          cur_dup;
    logic          cur_empty;
    logic          last_entry;
    logic          dup_any;
    logic          have_empty_any;
    logic [AW-1:0] empty_at_any;
    logic [NW-1:0] cnt_inc;

    ida_ram #(
        .WIDTH (NW + 1),
        .DEPTH (FREE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode the entry that returned from the RAM last cycle
    assign entry_valid    = ram_rdata[NW];
    assign entry_num      = ram_rdata[NW-1:0];
    assign cur_dup        = rd_pend_reg && entry_valid && (entry_num == val_reg);
    assign cur_empty      = rd_pend_reg && !entry_valid;
    assign last_entry     = rd_pend_reg && (rd_idx_reg == LAST_IDX);
    assign dup_any        = dup_reg || cur_dup;
    assign have_empty_any = have_empty_reg || cur_empty;
    assign empty_at_any   = cur_empty ? rd_idx_reg : empty_at_reg;
    assign cnt_inc        = next_unused_reg + {{(NW-1){1'b0}}, 1'b1};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_num_reg;
    assign m_tuser  = out_status_reg;

    // Sequencer: clear, accept, scan, hand over the result
    always_comb
    begin
        state_next       = state_reg;
        scan_addr_next   = scan_addr_reg;
        issue_done_next  = issue_done_reg;
        rd_pend_next     = rd_pend_reg;
        rd_idx_next      = rd_idx_reg;
        dup_next         = dup_reg;
        have_empty_next  = have_empty_reg;
        empty_at_next    = empty_at_reg;
        next_unused_next = next_unused_reg;
        sat_next         = sat_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        val_next         = val_reg;
        res_num_next     = res_num_reg;
        res_status_next  = res_status_reg;
        out_num_next     = out_num_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = rd_idx_reg;
        ram_wdata        = '0;
        ram_raddr        = scan_addr_reg;

        // Drop the output beat once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_addr_reg;
                ram_wdata = '0;
                if (scan_addr_reg == LAST_IDX)
                begin
                    scan_addr_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = s_tuser[0];
                    val_next        = s_tdata[NW-1:0];
                    scan_addr_next  = '0;
                    issue_done_next = 1'b0;
                    rd_pend_next    = 1'b0;
                    dup_next        = 1'b0;
                    have_empty_next = 1'b0;
                    empty_at_next   = '0;
                    if ((s_tuser[0] == OP_ALLOC) && (s_tuser[1] == MODE_UNUSED_FIRST)
                        && !sat_reg)
                    begin
                        // Take the counter without touching the store
                        res_num_next     = next_unused_reg;
                        res_status_next  = ST_OK;
                        next_unused_next = cnt_inc;
                        if (cnt_inc == NUM_ONES)
                        begin
                            sat_next = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle until the last slot
                if (!issue_done_reg)
                begin
                    rd_pend_next    = 1'b1;
                    rd_idx_next     = scan_addr_reg;
                    scan_addr_next  = scan_addr_reg + 1'b1;
                    issue_done_next = (scan_addr_reg == LAST_IDX);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                if (op_reg == OP_ALLOC)
                begin
                    if (rd_pend_reg && entry_valid)
                    begin
                        // Lowest occupied slot: hand it out and mark it empty
                        ram_we          = 1'b1;
                        ram_waddr       = rd_idx_reg;
                        ram_wdata       = {1'b0, entry_num};
                        res_num_next    = entry_num;
                        res_status_next = ST_OK;
                        rd_pend_next    = 1'b0;
                        state_next      = S_FINISH;
                    end
                    else if (last_entry)
                    begin
                        if (!sat_reg)
                        begin
                            res_num_next     = next_unused_reg;
                            res_status_next  = ST_OK;
                            next_unused_next = cnt_inc;
                            if (cnt_inc == NUM_ONES)
                            begin
                                sat_next = 1'b1;
                            end
                        end
                        else
                        begin
                            res_num_next    = '0;
                            res_status_next = ST_EXHAUSTED;
                        end
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    dup_next        = dup_any;
                    have_empty_next = have_empty_any;
                    empty_at_next   = empty_at_any;
                    if (last_entry)
                    begin
                        res_num_next = '0;
                        if (dup_any)
                        begin
                            res_status_next = ST_DUPLICATE;
                        end
                        else if (!have_empty_any)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            // Store in the highest empty slot
                            ram_we          = 1'b1;
                            ram_waddr       = empty_at_any;
                            ram_wdata       = {1'b1, val_reg};
                            res_status_next = ST_OK;
                        end
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_num_next    = 32'(res_num_reg);
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            scan_addr_reg   <= '0;
            issue_done_reg  <= 1'b0;
            rd_pend_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            dup_reg         <= 1'b0;
            have_empty_reg  <= 1'b0;
            empty_at_reg    <= '0;
            next_unused_reg <= '0;
            sat_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_addr_reg   <= scan_addr_next;
            issue_done_reg  <= issue_done_next;
            rd_pend_reg     <= rd_pend_next;
            rd_idx_reg      <= rd_idx_next;
            dup_reg         <= dup_next;
            have_empty_reg  <= have_empty_next;
            empty_at_reg    <= empty_at_next;
            next_unused_reg <= next_unused_next;
            sat_reg         <= sat_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        res_num_reg    <= res_num_next;
        res_status_reg <= res_status_next;
        out_num_reg    <= out_num_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTH
    // Counter stays used up once saturated
    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |=> sat_reg)
        else $error("counter saturation flag cleared");

    // A failed request never carries a number
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == 32'd0))
        else $error("nonzero number on a failed result");

    // An accepted beat moves on to a scan or straight to the result
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ((state_reg == S_SCAN) || (state_reg == S_FINISH)))
        else $error("accepted beat not processed");

    // The mode-0 counter path never scans the store
    a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == OP_ALLOC)
            && (s_tuser[1] == MODE_UNUSED_FIRST) && !sat_reg)
        |=> (state_reg == S_FINISH))
        else $error("counter allocation entered a scan");
`endif

endmodule

// ===== rtl/ida_ram.sv =====
// ----------------------------------------------------------------------------
// ida_ram
// Generic RAM with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
